### hdl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
`default_nettype none

package sitda_pkg;

    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int NUM_DIGITS  = 10;
    localparam int DIGIT_IDX_W = 4;
    localparam int DIGIT_W     = 4;
    localparam int WIDE_W      = 34;  // holds 9 * 10^9

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    localparam logic [WIDE_W-1:0] POW10 [NUM_DIGITS] = '{
        34'd1,
        34'd10,
        34'd100,
        34'd1000,
        34'd10000,
        34'd100000,
        34'd1000000,
        34'd10000000,
        34'd100000000,
        34'd1000000000
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGITS
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic in_negative;
        logic last_digit;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### hdl/sitda_in_if.sv
// Input channel: one signed integer per item.
`default_nettype none

interface sitda_in_if import sitda_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### hdl/sitda_out_if.sv
// Output channel: one ASCII character per item.
`default_nettype none

interface sitda_out_if import sitda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

### hdl/sitda_ctrl.sv
// Controller: sequences load, sign and digit emission for one number.
`default_nettype none

module sitda_ctrl import sitda_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_negative ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/sitda_dp.sv
// Datapath: magnitude and digit count, one decimal digit per step, output register.
`default_nettype none

module sitda_dp import sitda_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic signed [VALUE_W-1:0] in_value,
    input  wire dp_cmd_t                   cmd,
    output dp_stat_t                       stat,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [CHAR_W-1:0]              out_char_code,
    output logic                           out_last_char
);

    logic [VALUE_W-1:0]     rem_reg;
    logic [VALUE_W-1:0]     rem_next;
    logic [DIGIT_IDX_W-1:0] pos_reg;
    logic [DIGIT_IDX_W-1:0] pos_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic [CHAR_W-1:0]      char_next;
    logic                   last_reg;
    logic                   last_next;

    logic [VALUE_W-1:0]     raw;
    logic [VALUE_W-1:0]     mag_in;
    logic [DIGIT_IDX_W-1:0] msd_idx;
    logic [WIDE_W-1:0]      rem_wide;
    logic [WIDE_W-1:0]      mult;
    logic [WIDE_W-1:0]      sub;
    logic [DIGIT_W-1:0]     digit;
    logic [WIDE_W-1:0]      diff;

    // Two's complement magnitude; the most negative value maps to 2^31 unsigned.
    assign raw    = in_value;
    assign mag_in = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

    // Index of the most significant digit: number of powers 10^k (k >= 1) not above mag.
    always_comb
    begin
        msd_idx = '0;
        for (int k = 1; k < NUM_DIGITS; k++)
        begin
            if ({2'b00, mag_in} >= POW10[k])
            begin
                msd_idx = msd_idx + 1'b1;
            end
        end
    end

    // Digit at the current place: largest k with k * 10^pos <= rem.
    always_comb
    begin
        rem_wide = {2'b00, rem_reg};
        digit    = '0;
        sub      = '0;
        mult     = '0;
        for (int k = 1; k < 10; k++)
        begin
            mult = WIDE_W'(k) * POW10[pos_reg];
            if (rem_wide >= mult)
            begin
                digit = DIGIT_W'(k);
                sub   = mult;
            end
        end
        diff     = rem_wide - sub;
        rem_next = diff[VALUE_W-1:0];
    end

    assign stat.in_negative = in_value[VALUE_W-1];
    assign stat.last_digit  = (pos_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        pos_next       = pos_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load)
        begin
            pos_next = msd_idx;
        end
        if (cmd.emit_sign)
        begin
            char_next      = CHAR_MINUS;
            last_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (cmd.emit_digit)
        begin
            char_next      = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
            last_next      = (pos_reg == '0);
            out_valid_next = 1'b1;
            pos_next       = pos_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        if (cmd.load)
        begin
            rem_reg <= mag_in;
        end
        else if (cmd.emit_digit)
        begin
            rem_reg <= rem_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_char_code = char_reg;
    assign out_last_char = last_reg;

endmodule

`default_nettype wire

### hdl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per output item.
// Each input item yields its text most significant digit first, with a leading '-'
// for negative values and no leading zeros; the final character has last_char set.
// An item is first loaded (magnitude and digit count) and then its characters are
// emitted: the digit unit produces one digit per cycle, unless the output is stalled,
// into a single output register. A new item is taken once the last character of the
// previous one is in the output register.
`default_nettype none

module signed_int_to_decimal_ascii import sitda_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sitda_in_if.sink   din,
    sitda_out_if.source dout
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sitda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sitda_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_value      (din.value),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (dout.valid),
        .out_ready     (dout.ready),
        .out_char_code (dout.char_code),
        .out_last_char (dout.last_char)
    );

endmodule

`default_nettype wire

### hdl/sitda_chk.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none

module sitda_chk import sitda_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [CHAR_W-1:0] out_char_code,
    input wire logic              out_last_char
);

    // Output item holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char_code)
                                    && $stable(out_last_char))
        else $error("output item changed while stalled");

    // One number at a time: input closes right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again while converting");

    // Only '-' or a digit ever leaves the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char_code == CHAR_MINUS)
                      || ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + 8'd9)))
        else $error("output character is not a sign or digit");

    // The sign is never the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_char_code == CHAR_MINUS) |-> !out_last_char)
        else $error("sign flagged as last character");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_sitda_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (din.valid),
    .in_ready      (din.ready),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .out_char_code (dout.char_code),
    .out_last_char (dout.last_char)
);

`default_nettype wire

### tb/sv/signed_int_to_decimal_ascii_tb.sv
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
    import sitda_pkg::*;

    localparam int RADIX        = 10;
    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_FIRST   = 120;  // random items in this range run with no idling
    localparam int CALM_LAST    = 200;
    localparam int IDLE_PCT     = 9;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } text_char_t;

    // Holds the characters still owed by the converter, oldest first.
    class decimal_text_board;
        text_char_t pending_chars[$];
        int         mismatches;

        function void note_value(logic signed [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] raw;
            logic [VALUE_W-1:0] mag;
            logic [DIGIT_W-1:0] digits [NUM_DIGITS];
            int                 count;
            raw = value;
            // most negative value wraps to 2^31, which still fits unsigned
            mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
            count = 0;
            do
            begin
                digits[count] = DIGIT_W'(mag % RADIX);
                mag = mag / RADIX;
                count++;
            end while (mag != 0 && count < NUM_DIGITS);
            if (raw[VALUE_W-1])
                pending_chars.push_back('{char_code: CHAR_MINUS, last_char: 1'b0});
            for (int i = count; i > 0; i--)
                pending_chars.push_back('{char_code: CHAR_ZERO + digits[i-1],
                                         last_char: (i == 1)});
        endfunction

        function void check_char(logic [CHAR_W-1:0] char_code, logic last_char);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected char, expected none, got 0x%02h last=%0b",
                         $time, char_code, last_char);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (want.char_code !== char_code)
            begin
                $display("%0t: char_code mismatch, expected 0x%02h, got 0x%02h",
                         $time, want.char_code, char_code);
                mismatches++;
            end
            if (want.last_char !== last_char)
            begin
                $display("%0t: last_char mismatch, expected %0b, got %0b",
                         $time, want.last_char, last_char);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   cycle_count;

    decimal_text_board text_board;

    sitda_in_if  din_if ();
    sitda_out_if dout_if ();

    signed_int_to_decimal_ascii dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random backpressure, checked at the rising edge.
    initial
    begin
        dout_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            dout_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
        if (rst_n && dout_if.valid && dout_if.ready)
            text_board.check_char(dout_if.char_code, dout_if.last_char);

    task automatic send_value(input logic signed [VALUE_W-1:0] value);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            din_if.valid <= 1'b0;
            @(negedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.value <= value;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        text_board.note_value(value);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned ndig;
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3:
            begin
                case ($urandom_range(3))
                    0: return INT_MIN;
                    1: return INT_MAX;
                    2: return '0;
                    default: return -1;
                endcase
            end
            default:
            begin
                // pick the digit count first so every text length shows up
                ndig = $urandom_range(1, NUM_DIGITS);
                lo   = (ndig == 1) ? 0 : 32'(POW10[ndig-1]);
                hi   = (ndig == NUM_DIGITS) ? INT_MAX : 32'(POW10[ndig] - 1);
                mag  = $urandom_range(hi, lo);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    initial
    begin
        logic signed [VALUE_W-1:0] directed_values[$];
        text_board   = new();
        cycle_count  = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        din_if.valid = 1'b0;
        din_if.value = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_values = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
            32'sd99, 32'sd100, -32'sd100, 32'sd999999999, -32'sd999999999,
            32'sd1000000000, -32'sd1000000000, INT_MAX, -INT_MAX, INT_MIN,
            32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1234567890, -32'sd1234567890,
            32'sd1000000001, -32'sd2000000000
        };
        foreach (directed_values[i])
            send_value(directed_values[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = (n >= CALM_FIRST && n < CALM_LAST);
            send_value(pick_value());
        end
        no_idle = 1'b0;
        @(negedge clk);
        din_if.valid <= 1'b0;

        while (text_board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (text_board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
hdl/sitda_pkg.sv
hdl/sitda_in_if.sv
hdl/sitda_out_if.sv
hdl/sitda_ctrl.sv
hdl/sitda_dp.sv
hdl/signed_int_to_decimal_ascii.sv
hdl/sitda_chk.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
